@@ sv/seqa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seqa_pkg
// Shared types and constants for the spike event queue with step accumulator.
// ----------------------------------------------------------------------------
package seqa_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W      = 32;
  localparam int WEIGHT_W    = 16;
  localparam int STEP_W      = 16;
  localparam int SUM_W       = 24;
  localparam int QCOUNT_W    = 5;
  localparam int ACC_W       = WEIGHT_W + $clog2(QUEUE_DEPTH) + 1;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic signed [31:0] SUM_MAX = 32'sd8388607;
  localparam logic signed [31:0] SUM_MIN = -32'sd8388608;

  typedef logic [TIME_W-1:0]          time_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef logic [TIME_W:0]            deadline_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [CNT_W-1:0]           cnt_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    cell_op_e op;
    time_t    ev_time;
    weight_t  ev_weight;
  } cell_ctrl_t;

  function automatic sum_t sat_sum(acc_t acc);
    logic signed [31:0] wide;
    wide = 32'(acc);
    if (wide > SUM_MAX) begin
      return SUM_MAX[SUM_W-1:0];
    end else if (wide < SUM_MIN) begin
      return SUM_MIN[SUM_W-1:0];
    end
    return wide[SUM_W-1:0];
  endfunction

endpackage

@@ sv/seqa_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seqa_cell
// One slot of the sorted event chain: holds, takes the new event, takes the
// left neighbor on insert, or takes the right neighbor on pop.
// ----------------------------------------------------------------------------
module seqa_cell (
  input  logic                clk_i,
  input  seqa_pkg::cell_ctrl_t ctrl_i,
  input  logic                valid_i,
  input  logic                at_fill_i,
  input  logic                left_gt_i,
  input  seqa_pkg::time_t     left_time_i,
  input  seqa_pkg::weight_t   left_weight_i,
  input  seqa_pkg::time_t     right_time_i,
  input  seqa_pkg::weight_t   right_weight_i,
  output seqa_pkg::time_t     time_o,
  output seqa_pkg::weight_t   weight_o,
  output logic                gt_o
);

  seqa_pkg::time_t   time_q, time_d;
  seqa_pkg::weight_t weight_q, weight_d;

  assign gt_o     = valid_i && (time_q > ctrl_i.ev_time);
  assign time_o   = time_q;
  assign weight_o = weight_q;

  always_comb begin
    time_d   = time_q;
    weight_d = weight_q;
    case (ctrl_i.op)
      seqa_pkg::CELL_INSERT: begin
        if (left_gt_i) begin
          time_d   = left_time_i;
          weight_d = left_weight_i;
        end else if (gt_o || at_fill_i) begin
          time_d   = ctrl_i.ev_time;
          weight_d = ctrl_i.ev_weight;
        end
      end
      seqa_pkg::CELL_SHIFT: begin
        time_d   = right_time_i;
        weight_d = right_weight_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    time_q   <= time_d;
    weight_q <= weight_d;
  end

endmodule

@@ sv/spike_event_queue_accumulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spike_event_queue_accumulator
// Time-sorted spike event queue with a step command that drains due events.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result appears
// on the result ports for one cycle with done_o high and cannot be stalled.
// An add passes through the insert state, after which the result shows, and
// a full-queue add is rejected with the result on the next cycle. A step pops
// one due event per cycle from the head of the cell chain, and its result
// shows once no due event is left at the head. A new word may be taken in
// the cycle the result is shown.
module spike_event_queue_accumulator (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    command_i,
  input  logic [31:0]             event_time_i,
  input  logic signed [15:0]      spike_weight_i,
  input  logic [31:0]             current_time_i,
  output logic                    done_o,
  output logic signed [23:0]      pulse_sum_o,
  output logic                    accepted_o,
  output logic [4:0]              queue_count_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [15:0]             cfg_data_i
);

  localparam int N = seqa_pkg::QUEUE_DEPTH;

  seqa_pkg::state_e    state_q, state_d;
  seqa_pkg::cnt_t      count_q, count_d;
  seqa_pkg::acc_t      acc_q, acc_d;
  seqa_pkg::deadline_t deadline_q, deadline_d;
  seqa_pkg::time_t     ev_time_q, ev_time_d;
  seqa_pkg::weight_t   ev_weight_q, ev_weight_d;
  logic [seqa_pkg::STEP_W-1:0] step_q;
  logic                done_q, done_d;
  seqa_pkg::sum_t      sum_q, sum_d;
  logic                accepted_q, accepted_d;
  seqa_pkg::cnt_t      qcount_q, qcount_d;

  seqa_pkg::cell_ctrl_t ctrl;
  seqa_pkg::time_t     cell_time   [N];
  seqa_pkg::weight_t   cell_weight [N];
  logic [N-1:0]        cell_gt;
  logic                pop;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != seqa_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 16'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      step_q <= cfg_data_i;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    seqa_pkg::time_t   l_time, r_time;
    seqa_pkg::weight_t l_weight, r_weight;
    logic              l_gt;

    if (k == 0) begin : g_first
      assign l_gt     = 1'b0;
      assign l_time   = '0;
      assign l_weight = '0;
    end else begin : g_mid
      assign l_gt     = cell_gt[k-1];
      assign l_time   = cell_time[k-1];
      assign l_weight = cell_weight[k-1];
    end

    if (k == N - 1) begin : g_last
      assign r_time   = '0;
      assign r_weight = '0;
    end else begin : g_inner
      assign r_time   = cell_time[k+1];
      assign r_weight = cell_weight[k+1];
    end

    seqa_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .valid_i       (count_q > seqa_pkg::CNT_W'(k)),
      .at_fill_i     (count_q == seqa_pkg::CNT_W'(k)),
      .left_gt_i     (l_gt),
      .left_time_i   (l_time),
      .left_weight_i (l_weight),
      .right_time_i  (r_time),
      .right_weight_i(r_weight),
      .time_o        (cell_time[k]),
      .weight_o      (cell_weight[k]),
      .gt_o          (cell_gt[k])
    );
  end

  assign pop = (count_q != '0) && ({1'b0, cell_time[0]} < deadline_q);

  always_comb begin
    state_d         = state_q;
    count_d         = count_q;
    acc_d           = acc_q;
    deadline_d      = deadline_q;
    ev_time_d       = ev_time_q;
    ev_weight_d     = ev_weight_q;
    done_d          = 1'b0;
    sum_d           = sum_q;
    accepted_d      = accepted_q;
    qcount_d        = qcount_q;
    ctrl.op         = seqa_pkg::CELL_HOLD;
    ctrl.ev_time    = ev_time_q;
    ctrl.ev_weight  = ev_weight_q;
    case (state_q)
      seqa_pkg::ST_IDLE: begin
        if (start) begin
          if (command_i == seqa_pkg::CMD_STEP) begin
            deadline_d = {1'b0, current_time_i} + seqa_pkg::deadline_t'(step_q);
            acc_d      = '0;
            state_d    = seqa_pkg::ST_DRAIN;
          end else if (count_q == seqa_pkg::CNT_W'(N)) begin
            done_d     = 1'b1;
            sum_d      = '0;
            accepted_d = 1'b0;
            qcount_d   = count_q;
          end else begin
            ev_time_d   = event_time_i;
            ev_weight_d = spike_weight_i;
            state_d     = seqa_pkg::ST_INSERT;
          end
        end
      end
      seqa_pkg::ST_INSERT: begin
        ctrl.op    = seqa_pkg::CELL_INSERT;
        count_d    = count_q + 1'b1;
        done_d     = 1'b1;
        sum_d      = '0;
        accepted_d = 1'b1;
        qcount_d   = count_q + 1'b1;
        state_d    = seqa_pkg::ST_IDLE;
      end
      seqa_pkg::ST_DRAIN: begin
        if (pop) begin
          ctrl.op = seqa_pkg::CELL_SHIFT;
          acc_d   = acc_q + seqa_pkg::acc_t'(cell_weight[0]);
          count_d = count_q - 1'b1;
        end else begin
          done_d     = 1'b1;
          sum_d      = seqa_pkg::sat_sum(acc_q);
          accepted_d = 1'b1;
          qcount_d   = count_q;
          state_d    = seqa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = seqa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= seqa_pkg::ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    deadline_q  <= deadline_d;
    ev_time_q   <= ev_time_d;
    ev_weight_q <= ev_weight_d;
    sum_q       <= sum_d;
    accepted_q  <= accepted_d;
    qcount_q    <= qcount_d;
  end

  assign done_o        = done_q;
  assign pulse_sum_o   = sum_q;
  assign accepted_o    = accepted_q;
  assign queue_count_o = seqa_pkg::QCOUNT_W'(qcount_q);

endmodule

@@ sv/seqa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seqa_checker
// Port-level checks for the spike event queue, bound to the top level.
// ----------------------------------------------------------------------------
module seqa_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic signed [23:0] pulse_sum_o,
  input logic               accepted_o,
  input logic [4:0]         queue_count_o
);

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (queue_count_o <= 5'(seqa_pkg::QUEUE_DEPTH)))
    else $error("queue count beyond depth");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !accepted_o) |->
      (pulse_sum_o == '0) && (queue_count_o == 5'(seqa_pkg::QUEUE_DEPTH)))
    else $error("drop reported while queue not full");

  a_word_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted word neither in progress nor done");

  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) || $past(start)))
    else $error("result without an accepted word");

endmodule

bind spike_event_queue_accumulator seqa_checker u_seqa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .pulse_sum_o  (pulse_sum_o),
  .accepted_o   (accepted_o),
  .queue_count_o(queue_count_o)
);

@@ test/seqa_queue_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seqa_queue_check
// Watches the word, result and step-length channels of the spike event queue.
// It keeps its own time-sorted copy of the held events and the step length.
// For each accepted word it works out the result and queues it. Each done_o
// result is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module seqa_queue_check
  import seqa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic                command_i,
  input  time_t               event_time_i,
  input  weight_t             spike_weight_i,
  input  time_t               current_time_i,
  input  logic                done_i,
  input  sum_t                pulse_sum_i,
  input  logic                accepted_i,
  input  logic [QCOUNT_W-1:0] queue_count_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [STEP_W-1:0]   cfg_data_i,
  output int                  outstanding_o,
  output int                  mismatches_o
);

  typedef struct {
    sum_t                pulse_sum;
    logic                accepted;
    logic [QCOUNT_W-1:0] queue_count;
  } outcome_t;

  time_t             held_time   [QUEUE_DEPTH];
  weight_t           held_weight [QUEUE_DEPTH];
  int                held_count = 0;
  logic [STEP_W-1:0] step_len   = 16'd1;
  outcome_t          pending_q[$];
  outcome_t          want;
  int                errors     = 0;

  assign mismatches_o = errors;

  function automatic outcome_t add_event(time_t t, weight_t w);
    outcome_t r;
    int       pos;
    r.pulse_sum = '0;
    r.accepted  = 1'b0;
    if (held_count < QUEUE_DEPTH) begin
      pos = held_count;
      while (pos > 0 && held_time[pos-1] > t) begin
        held_time[pos]   = held_time[pos-1];
        held_weight[pos] = held_weight[pos-1];
        pos--;
      end
      held_time[pos]   = t;
      held_weight[pos] = w;
      held_count++;
      r.accepted = 1'b1;
    end
    r.queue_count = held_count[QCOUNT_W-1:0];
    return r;
  endfunction

  function automatic outcome_t drain_due(time_t now);
    outcome_t  r;
    deadline_t limit;
    int        total;
    int        n;
    limit = {1'b0, now} + deadline_t'(step_len);
    total = 0;
    n     = 0;
    while (n < held_count && deadline_t'(held_time[n]) < limit) begin
      total += held_weight[n];
      n++;
    end
    for (int k = 0; k + n < held_count; k++) begin
      held_time[k]   = held_time[k+n];
      held_weight[k] = held_weight[k+n];
    end
    held_count -= n;
    if (total > SUM_MAX) total = SUM_MAX;
    if (total < SUM_MIN) total = SUM_MIN;
    r.pulse_sum   = sum_t'(total);
    r.accepted    = 1'b1;
    r.queue_count = held_count[QCOUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count = 0;
      step_len   = 16'd1;
      pending_q.delete();
      outstanding_o <= 0;
    end else begin
      if (done_i) begin
        if (pending_q.size() == 0) begin
          $error("unexpected result: pulse_sum %0d accepted %0b queue_count %0d",
                 pulse_sum_i, accepted_i, queue_count_i);
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (pulse_sum_i !== want.pulse_sum) begin
            $error("pulse_sum mismatch: expected %0d, actual %0d",
                   want.pulse_sum, pulse_sum_i);
            errors++;
          end
          if (accepted_i !== want.accepted) begin
            $error("accepted mismatch: expected %0b, actual %0b",
                   want.accepted, accepted_i);
            errors++;
          end
          if (queue_count_i !== want.queue_count) begin
            $error("queue_count mismatch: expected %0d, actual %0d",
                   want.queue_count, queue_count_i);
            errors++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) step_len = cfg_data_i;
      if (start_i && !busy_i) begin
        if (command_i == CMD_ADD) begin
          pending_q.push_back(add_event(event_time_i, spike_weight_i));
        end else begin
          pending_q.push_back(drain_due(current_time_i));
        end
      end
      outstanding_o <= pending_q.size();
    end
  end

endmodule

@@ test/spike_event_queue_accumulator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spike_event_queue_accumulator_tb
// Drives add and step words into the spike event queue. A directed run covers
// the empty step, a full queue with a dropped add, equal times, the deadline
// boundary and deadlines past 32 bits. Random phases follow, each with its own
// step length, 0 and 65535 among them. Words carry random gaps, with one calm
// stretch and with periodic waits for all results. Checking is done in
// seqa_queue_check.
// ----------------------------------------------------------------------------
module spike_event_queue_accumulator_tb;
  import seqa_pkg::*;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start          = 1'b0;
  logic                busy;
  logic                command_i      = CMD_ADD;
  time_t               event_time_i   = '0;
  weight_t             spike_weight_i = '0;
  time_t               current_time_i = '0;
  logic                done_o;
  sum_t                pulse_sum_o;
  logic                accepted_o;
  logic [QCOUNT_W-1:0] queue_count_o;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [STEP_W-1:0]   cfg_data_i     = '0;

  int    outstanding;
  int    mismatches;
  logic  calm     = 1'b0;
  time_t sim_tick = '0;

  always #6 clk_i = ~clk_i;

  spike_event_queue_accumulator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .event_time_i   (event_time_i),
    .spike_weight_i (spike_weight_i),
    .current_time_i (current_time_i),
    .done_o         (done_o),
    .pulse_sum_o    (pulse_sum_o),
    .accepted_o     (accepted_o),
    .queue_count_o  (queue_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  seqa_queue_check u_queue_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .command_i      (command_i),
    .event_time_i   (event_time_i),
    .spike_weight_i (spike_weight_i),
    .current_time_i (current_time_i),
    .done_i         (done_o),
    .pulse_sum_i    (pulse_sum_o),
    .accepted_i     (accepted_o),
    .queue_count_i  (queue_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .outstanding_o  (outstanding),
    .mismatches_o   (mismatches)
  );

  task automatic send_word(logic cmd, time_t et, weight_t wt, time_t ct);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(99) < 12) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    command_i      <= cmd;
    event_time_i   <= et;
    spike_weight_i <= wt;
    current_time_i <= ct;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_step_length(logic [STEP_W-1:0] value);
    wait_drained();
    while ($urandom_range(99) < 12) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= STEP_W'($urandom);
  endtask

  task automatic random_word();
    int      pick;
    time_t   et;
    time_t   ct;
    weight_t wt;
    pick = $urandom_range(99);
    wt   = weight_t'($urandom);
    et   = time_t'($urandom);
    ct   = time_t'($urandom);
    if (pick < 58) begin
      if ($urandom_range(9) != 0) et = sim_tick + time_t'($urandom_range(40));
      send_word(CMD_ADD, et, wt, ct);
    end else begin
      if (pick == 99) begin
        ct = '1;
      end else if ($urandom_range(19) != 0) begin
        sim_tick += time_t'($urandom_range(6));
        ct = sim_tick;
      end
      send_word(CMD_STEP, et, wt, ct);
    end
  endtask

  initial begin
    logic [STEP_W-1:0] phase_len [5];
    time_t             et;
    weight_t           wt;
    int                count;

    phase_len[0] = 16'd0;
    phase_len[1] = 16'hFFFF;
    phase_len[2] = STEP_W'($urandom_range(64, 2));
    phase_len[3] = 16'd1;
    phase_len[4] = STEP_W'($urandom);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(CMD_STEP, '1, weight_t'(16'h7FFF), '0);
    for (int i = 0; i < QUEUE_DEPTH + 1; i++) begin
      et = (i == 0) ? time_t'(0) : (i == 1) ? time_t'('1) :
           (i < 5) ? time_t'(100) : time_t'(i * 1000);
      wt = i[0] ? weight_t'(16'h8000) : weight_t'(16'h7FFF);
      send_word(CMD_ADD, et, wt, time_t'($urandom));
    end
    send_word(CMD_STEP, time_t'($urandom), weight_t'($urandom), 32'd99);
    send_word(CMD_STEP, time_t'($urandom), weight_t'($urandom), 32'd100);
    send_word(CMD_STEP, time_t'($urandom), weight_t'($urandom), '1);
    send_word(CMD_ADD, '1, weight_t'(16'hFFFF), '1);
    send_word(CMD_STEP, '0, weight_t'(16'h0000), '1);

    count = 0;
    for (int p = 0; p < 5; p++) begin
      write_step_length(phase_len[p]);
      sim_tick = (p == 2) ? time_t'(32'hFFFF_FF80) : time_t'($urandom_range(1000));
      for (int j = 0; j < 386; j++) begin
        calm = (count >= 700 && count < 1000);
        random_word();
        count++;
        if (count % 250 == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("spike_event_queue_accumulator_tb OK");
    end else begin
      $display("spike_event_queue_accumulator_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("spike_event_queue_accumulator_tb NOT OK");
    $finish;
  end

endmodule
